// ===== sv/arpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP responder package
// Shared constants, payload types and reply mapping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

  localparam int unsigned FrameLen  = 42;
  localparam int unsigned CountW    = 6;
  localparam int unsigned NumBanks  = 2;
  localparam int unsigned RamDepth  = NumBanks * FrameLen;
  localparam int unsigned RamAw     = $clog2(RamDepth);
  localparam int unsigned QueueDepth = NumBanks;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 48;

  localparam logic [CfgIdxW-1:0] CfgOwnMac = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnIp  = 1'd1;

  localparam logic [CountW-1:0] LastIdx      = 6'd41;
  localparam logic [CountW-1:0] FrameLenC    = 6'd42;
  localparam logic [CountW-1:0] OfsEthDst    = 6'd0;
  localparam logic [CountW-1:0] OfsEthSrc    = 6'd6;
  localparam logic [CountW-1:0] OfsEthertype = 6'd12;
  localparam logic [CountW-1:0] OfsOpcode    = 6'd20;
  localparam logic [CountW-1:0] OfsSenderMac = 6'd22;
  localparam logic [CountW-1:0] OfsSenderIp  = 6'd28;
  localparam logic [CountW-1:0] OfsTargetMac = 6'd32;
  localparam logic [CountW-1:0] OfsTargetIp  = 6'd38;

  localparam logic [15:0] EthertypeArp = 16'h0806;
  localparam logic [15:0] OpRequest    = 16'h0001;
  localparam logic [7:0]  OpReplyHi    = 8'h00;
  localparam logic [7:0]  OpReplyLo    = 8'h02;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  typedef struct packed {
    logic             we;
    logic [RamAw-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } bk_status_t;

  function automatic logic [RamAw-1:0] ram_addr(logic bank, logic [CountW-1:0] idx);
    logic [RamAw-1:0] base;
    base = bank ? RamAw'(FrameLen) : '0;
    return base + RamAw'(idx);
  endfunction

  function automatic logic [CountW-1:0] reply_src(logic [CountW-1:0] k);
    logic [CountW-1:0] src;
    case (k) inside
      [OfsEthDst : OfsEthDst + 6'd5]:       src = k + (OfsEthSrc - OfsEthDst);
      [OfsTargetMac : OfsTargetMac + 6'd5]: src = k - (OfsTargetMac - OfsEthSrc);
      [OfsSenderIp : OfsSenderIp + 6'd3]:   src = k + (OfsTargetIp - OfsSenderIp);
      [OfsTargetIp : OfsTargetIp + 6'd3]:   src = k - (OfsTargetIp - OfsSenderIp);
      default:                              src = k;
    endcase
    return src;
  endfunction

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] j);
    return mac[(3'd5 - j) * 8 +: 8];
  endfunction

  function automatic logic [7:0] reply_byte(logic [CountW-1:0] k, logic [7:0] stored,
                                            logic [47:0] mac);
    logic [7:0] b;
    case (k) inside
      [OfsEthSrc : OfsEthSrc + 6'd5]:       b = mac_byte(mac, 3'(k - OfsEthSrc));
      [OfsSenderMac : OfsSenderMac + 6'd5]: b = mac_byte(mac, 3'(k - OfsSenderMac));
      OfsOpcode:                            b = OpReplyHi;
      OfsOpcode + 6'd1:                     b = OpReplyLo;
      default:                              b = stored;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arpr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/arpr_front.sv =====
// ----------------------------------------------------------------------------
// ARP responder front end
// Stores received bytes into a free bank and checks the request at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rx_valid_i,
  output      logic                 rx_ready_o,
  input  wire arpr_pkg::rx_item_t   rx_i,
  input  wire logic [31:0]          own_ip_i,
  input  wire arpr_pkg::bk_status_t bk_status_i,
  output      arpr_pkg::ram_wr_t    ram_wr_o,
  output      logic                 push_o,
  output      logic                 push_bank_o
);

  logic [arpr_pkg::CountW-1:0]   count_q, count_d;
  logic                          bank_q, bank_d;
  logic [arpr_pkg::NumBanks-1:0] busy_q, busy_d;
  logic [15:0]                   etype_q, etype_d;
  logic [15:0]                   opc_q, opc_d;
  logic [31:0]                   tip_q, tip_d;
  logic                          accept;
  logic                          store;
  logic                          len_ok;
  logic                          send;

  assign rx_ready_o = !busy_q[bank_q];
  assign accept     = rx_valid_i && rx_ready_o;
  assign store      = accept && (count_q < arpr_pkg::FrameLenC);
  assign len_ok     = count_q >= arpr_pkg::LastIdx;

  assign ram_wr_o.we   = store;
  assign ram_wr_o.addr = arpr_pkg::ram_addr(bank_q, count_q);
  assign ram_wr_o.data = rx_i.rx_byte;

  always_comb begin
    etype_d = etype_q;
    opc_d   = opc_q;
    tip_d   = tip_q;
    if (store) begin
      case (count_q)
        arpr_pkg::OfsEthertype:        etype_d[15:8] = rx_i.rx_byte;
        arpr_pkg::OfsEthertype + 6'd1: etype_d[7:0]  = rx_i.rx_byte;
        arpr_pkg::OfsOpcode:           opc_d[15:8]   = rx_i.rx_byte;
        arpr_pkg::OfsOpcode + 6'd1:    opc_d[7:0]    = rx_i.rx_byte;
        arpr_pkg::OfsTargetIp:         tip_d[31:24]  = rx_i.rx_byte;
        arpr_pkg::OfsTargetIp + 6'd1:  tip_d[23:16]  = rx_i.rx_byte;
        arpr_pkg::OfsTargetIp + 6'd2:  tip_d[15:8]   = rx_i.rx_byte;
        arpr_pkg::OfsTargetIp + 6'd3:  tip_d[7:0]    = rx_i.rx_byte;
        default: ;
      endcase
    end
  end

  assign send = accept && rx_i.frame_end && len_ok && (etype_d == arpr_pkg::EthertypeArp) &&
                (opc_d == arpr_pkg::OpRequest) && (tip_d == own_ip_i);

  assign push_o      = send;
  assign push_bank_o = bank_q;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (rx_i.frame_end) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + 6'd1;
      end
    end
    bank_d = send ? !bank_q : bank_q;
    busy_d = busy_q;
    if (bk_status_i.done) begin
      busy_d[bk_status_i.bank] = 1'b0;
    end
    if (send) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      count_q <= count_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    etype_q <= etype_d;
    opc_q   <= opc_d;
    tip_q   <= tip_d;
  end

endmodule

`default_nettype wire

// ===== sv/arpr_queue.sv =====
// ----------------------------------------------------------------------------
// ARP responder job queue
// Short FIFO of bank numbers holding accepted requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire logic push_bank_i,
  input  wire logic pop_i,
  output      logic valid_o,
  output      logic bank_o
);

  localparam int unsigned PtrW = $clog2(arpr_pkg::QueueDepth);

  logic [arpr_pkg::QueueDepth-1:0] entry_q, entry_d;
  logic [PtrW-1:0]                 wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]                   fill_q, fill_d;

  assign valid_o = fill_q != '0;
  assign bank_o  = entry_q[rd_ptr_q];

  always_comb begin
    entry_d  = entry_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      entry_d[wr_ptr_q] = push_bank_i;
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== sv/arpr_back.sv =====
// ----------------------------------------------------------------------------
// ARP responder back end
// Reads a stored request in reply order and streams the 42-byte reply.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  input  wire logic                         job_bank_i,
  output      logic                         job_pop_o,
  input  wire logic [47:0]                  own_mac_i,
  output      logic                         ram_re_o,
  output      logic [arpr_pkg::RamAw-1:0]   ram_raddr_o,
  input  wire logic [7:0]                   ram_rdata_i,
  output      arpr_pkg::bk_status_t         status_o,
  output      logic                         tx_valid_o,
  input  wire logic                         tx_ready_i,
  output      arpr_pkg::tx_item_t           tx_o
);

  logic                        active_q, active_d;
  logic                        bank_q, bank_d;
  logic [arpr_pkg::CountW-1:0] k_q, k_d;
  logic                        s1_valid_q, s1_valid_d;
  logic [arpr_pkg::CountW-1:0] s1_k_q, s1_k_d;
  logic                        out_valid_q, out_valid_d;
  arpr_pkg::tx_item_t          out_q, out_d;
  logic                        advance;
  logic                        issue;
  logic                        start;

  assign advance = !out_valid_q || tx_ready_i;
  assign issue   = active_q && advance;
  assign start   = !active_q && job_valid_i;

  assign job_pop_o   = start;
  assign ram_re_o    = issue;
  assign ram_raddr_o = arpr_pkg::ram_addr(bank_q, arpr_pkg::reply_src(k_q));

  assign status_o.done = issue && (k_q == arpr_pkg::LastIdx);
  assign status_o.bank = bank_q;

  assign tx_valid_o = out_valid_q;
  assign tx_o       = out_q;

  always_comb begin
    active_d    = active_q;
    bank_d      = bank_q;
    k_d         = k_q;
    s1_valid_d  = s1_valid_q;
    s1_k_d      = s1_k_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (start) begin
      active_d = 1'b1;
      bank_d   = job_bank_i;
      k_d      = '0;
    end
    if (advance) begin
      out_valid_d   = s1_valid_q;
      out_d.tx_byte = arpr_pkg::reply_byte(s1_k_q, ram_rdata_i, own_mac_i);
      out_d.tx_last = s1_k_q == arpr_pkg::LastIdx;
      s1_valid_d    = issue;
      s1_k_d        = k_q;
    end
    if (issue) begin
      k_d = k_q + 6'd1;
      if (k_q == arpr_pkg::LastIdx) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    k_q    <= k_d;
    s1_k_q <= s1_k_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/arp_request_responder_core.sv =====
// ----------------------------------------------------------------------------
// ARP request responder core
// Answers ARP requests for the configured IPv4 address with a 42-byte reply.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------
//  rx      | rx_valid_i, rx_ready_o | rx_i: rx_byte, frame_end
//  tx      | tx_valid_o, tx_ready_i | tx_o: tx_byte, tx_last
//  cfg     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// While rx_ready_o is high, received bytes go one per cycle into one of two frame banks.
// A reply starts when the back end takes the queued request; the buffer read port and
// output register feed it out at one byte per cycle while tx_ready_i is high.
// rx_ready_o is low while both banks hold replies that are not yet fully read out.
// Reset clears the control state only; the frame banks need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_request_responder_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            rx_valid_i,
  output      logic                            rx_ready_o,
  input  wire arpr_pkg::rx_item_t              rx_i,
  output      logic                            tx_valid_o,
  input  wire logic                            tx_ready_i,
  output      arpr_pkg::tx_item_t              tx_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [arpr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [arpr_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [47:0]                own_mac_q, own_mac_d;
  logic [31:0]                own_ip_q, own_ip_d;
  arpr_pkg::ram_wr_t          ram_wr;
  arpr_pkg::bk_status_t       bk_status;
  logic                       push;
  logic                       push_bank;
  logic                       job_valid;
  logic                       job_bank;
  logic                       job_pop;
  logic                       ram_re;
  logic [arpr_pkg::RamAw-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  always_comb begin
    own_mac_d = own_mac_q;
    own_ip_d  = own_ip_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        arpr_pkg::CfgOwnMac: own_mac_d = cfg_data_i;
        arpr_pkg::CfgOwnIp:  own_ip_d  = cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else begin
      own_mac_q <= own_mac_d;
      own_ip_q  <= own_ip_d;
    end
  end

  arpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_i        (rx_i),
    .own_ip_i    (own_ip_q),
    .bk_status_i (bk_status),
    .ram_wr_o    (ram_wr),
    .push_o      (push),
    .push_bank_o (push_bank)
  );

  arpr_ram #(
    .Width (8),
    .Depth (arpr_pkg::RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  arpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_bank_i (push_bank),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .bank_o      (job_bank)
  );

  arpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_bank_i  (job_bank),
    .job_pop_o   (job_pop),
    .own_mac_i   (own_mac_q),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .status_o    (bk_status),
    .tx_valid_o  (tx_valid_o),
    .tx_ready_i  (tx_ready_i),
    .tx_o        (tx_o)
  );

endmodule

`default_nettype wire

// ===== sv/arpr_checker.sv =====
// ----------------------------------------------------------------------------
// ARP responder port checker
// Checks reply framing and fixed reply fields as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tx_valid_o,
  input  wire logic                          tx_ready_i,
  input  wire arpr_pkg::tx_item_t            tx_o
);

  logic [arpr_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        tx_xfer;

  assign tx_xfer = tx_valid_o && tx_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (tx_xfer) begin
      cnt_d = tx_o.tx_last ? '0 : cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && !tx_ready_i |=> tx_valid_o && $stable(tx_o))
    else $error("Stalled reply byte changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_xfer |-> (tx_o.tx_last == (cnt_q == arpr_pkg::LastIdx)))
    else $error("Reply end mark is not on the 42nd byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_xfer && (cnt_q == arpr_pkg::OfsOpcode + 6'd1) |-> tx_o.tx_byte == arpr_pkg::OpReplyLo)
    else $error("Reply opcode is not 2.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_xfer && (cnt_q == arpr_pkg::OfsEthertype) |-> tx_o.tx_byte == 8'h08)
    else $error("Reply ethertype high byte is wrong.");

endmodule

bind arp_request_responder_core arpr_checker u_arpr_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP request responder core testbench
// Streams Ethernet frames byte by byte into the core and predicts every
// reply byte from its own copy of the frame store and the address registers.
// Each reply transfer is compared in order against the predicted bytes.
// Directed frames cover reset defaults, the register extremes, long, short
// and broken requests and a held sink; randomized traffic stalls both sides.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int FrameBytes   = 42;
  localparam int BufBytes     = 80;
  localparam int EthSrcAt     = 6;
  localparam int TypeAt       = 12;
  localparam int OpAt         = 20;
  localparam int SndMacAt     = 22;
  localparam int SndIpAt      = 28;
  localparam int TgtMacAt     = 32;
  localparam int TgtIpAt      = 38;
  localparam int SettleCycles = 12;
  localparam int IdleLimit    = 3000;
  localparam int FillHold     = 400;

  localparam logic [15:0] ArpType    = 16'h0806;
  localparam logic [15:0] ArpRequest = 16'h0001;
  localparam logic [15:0] ArpReply   = 16'h0002;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                rx_valid_i;
  logic                                rx_ready_o;
  arpr_pkg::rx_item_t                  rx_i;
  logic                                tx_valid_o;
  logic                                tx_ready_i;
  arpr_pkg::tx_item_t                  tx_o;
  logic                                cfg_we_i;
  logic [arpr_pkg::CfgIdxW-1:0]        cfg_idx_i;
  logic [arpr_pkg::CfgDataW-1:0]       cfg_data_i;

  logic [47:0]        own_mac_q;
  logic [31:0]        own_ip_q;
  logic [7:0]         rx_frame [FrameBytes];
  int                 rx_fill;
  arpr_pkg::tx_item_t reply_q [$];

  logic [7:0]  frame_buf [BufBytes];
  int          frame_len;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          hold_left;
  int          errors;
  int          quiet_cycles;

  arp_request_responder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_i       (rx_i),
    .tx_valid_o (tx_valid_o),
    .tx_ready_i (tx_ready_i),
    .tx_o       (tx_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] reply_at(int k);
    logic [7:0] b;
    if (k < 6) begin
      b = rx_frame[EthSrcAt + k];
    end else if (k < 12) begin
      b = own_mac_q[8 * (11 - k) +: 8];
    end else if (k == OpAt) begin
      b = ArpReply[15:8];
    end else if (k == OpAt + 1) begin
      b = ArpReply[7:0];
    end else if (k >= SndMacAt && k < SndMacAt + 6) begin
      b = own_mac_q[8 * (SndMacAt + 5 - k) +: 8];
    end else if (k >= SndIpAt && k < SndIpAt + 4) begin
      b = rx_frame[k + (TgtIpAt - SndIpAt)];
    end else if (k >= TgtMacAt && k < TgtMacAt + 6) begin
      b = rx_frame[k - TgtMacAt + EthSrcAt];
    end else if (k >= TgtIpAt) begin
      b = rx_frame[k - (TgtIpAt - SndIpAt)];
    end else begin
      b = rx_frame[k];
    end
    return b;
  endfunction

  function automatic void take_rx_byte(arpr_pkg::rx_item_t it);
    logic [15:0]        ethertype;
    logic [15:0]        opcode;
    logic [31:0]        target;
    arpr_pkg::tx_item_t r;
    if (rx_fill < FrameBytes) begin
      rx_frame[rx_fill] = it.rx_byte;
      rx_fill++;
    end
    if (it.frame_end) begin
      if (rx_fill == FrameBytes) begin
        ethertype = {rx_frame[TypeAt], rx_frame[TypeAt + 1]};
        opcode    = {rx_frame[OpAt], rx_frame[OpAt + 1]};
        target    = {rx_frame[TgtIpAt], rx_frame[TgtIpAt + 1],
                     rx_frame[TgtIpAt + 2], rx_frame[TgtIpAt + 3]};
        if (ethertype == ArpType && opcode == ArpRequest && target == own_ip_q) begin
          for (int k = 0; k < FrameBytes; k++) begin
            r.tx_byte = reply_at(k);
            r.tx_last = (k == FrameBytes - 1);
            reply_q.push_back(r);
          end
        end
      end
      rx_fill = 0;
    end
  endfunction

  always @(posedge clk_i) begin : check_tx
    arpr_pkg::tx_item_t want;
    if (rst_ni && tx_valid_o && tx_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected tx transfer: tx_byte %h tx_last %b", tx_o.tx_byte, tx_o.tx_last);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (tx_o.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", want.tx_byte, tx_o.tx_byte);
          errors++;
        end
        if (tx_o.tx_last !== want.tx_last) begin
          $error("tx_last: expected %b, actual %b", want.tx_last, tx_o.tx_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid_i && rx_ready_o) || (tx_valid_o && tx_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    tx_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        tx_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        tx_ready_i <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    arpr_pkg::rx_item_t it;
    it.rx_byte   = b;
    it.frame_end = last;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_i       <= it;
    do @(posedge clk_i); while (!rx_ready_o);
    take_rx_byte(it);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_len; i++) begin
      send_byte(frame_buf[i], i == frame_len - 1);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [arpr_pkg::CfgIdxW-1:0] idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == arpr_pkg::CfgOwnMac) begin
      own_mac_q = data;
    end else if (idx == arpr_pkg::CfgOwnIp) begin
      own_ip_q = data[31:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic make_request(logic [31:0] tip);
    for (int i = 0; i < BufBytes; i++) begin
      frame_buf[i] = 8'($urandom);
    end
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < 6; i++) begin
        frame_buf[i] = 8'hFF;
      end
    end
    frame_buf[TypeAt]     = ArpType[15:8];
    frame_buf[TypeAt + 1] = ArpType[7:0];
    frame_buf[14]         = 8'h00;
    frame_buf[15]         = 8'h01;
    frame_buf[16]         = 8'h08;
    frame_buf[17]         = 8'h00;
    frame_buf[18]         = 8'h06;
    frame_buf[19]         = 8'h04;
    frame_buf[OpAt]       = ArpRequest[15:8];
    frame_buf[OpAt + 1]   = ArpRequest[7:0];
    for (int i = 0; i < 4; i++) begin
      frame_buf[TgtIpAt + i] = tip[8 * (3 - i) +: 8];
    end
    frame_len = FrameBytes;
  endtask

  task automatic fill_addresses(logic [7:0] v);
    for (int i = 0; i < 12; i++) begin
      frame_buf[i] = v;
    end
    for (int i = SndMacAt; i < TgtIpAt; i++) begin
      frame_buf[i] = v;
    end
  endtask

  task automatic random_frame();
    int sel;
    sel = $urandom_range(99);
    make_request(own_ip_q);
    if (sel < 45) begin
      frame_len = FrameBytes;
    end else if (sel < 60) begin
      frame_len = $urandom_range(BufBytes - 16, FrameBytes + 1);
    end else if (sel < 68) begin
      frame_buf[TypeAt + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    end else if (sel < 76) begin
      frame_buf[OpAt + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    end else if (sel < 84) begin
      frame_buf[TgtIpAt + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    end else if (sel < 92) begin
      frame_len = $urandom_range(FrameBytes - 1, 1);
    end else begin
      for (int i = 0; i < BufBytes; i++) begin
        frame_buf[i] = 8'($urandom);
      end
      frame_len = $urandom_range(BufBytes - 16, 1);
    end
  endtask

  task automatic test_reset_defaults();
    make_request(32'h0);
    send_frame();
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(arpr_pkg::CfgOwnMac, 48'hFFFF_FFFF_FFFF);
    write_reg(arpr_pkg::CfgOwnIp, 48'hFFFF_FFFF);
    make_request(32'hFFFF_FFFF);
    fill_addresses(8'hFF);
    send_frame();
    settle();
  endtask

  task automatic test_frame_corners();
    write_reg(arpr_pkg::CfgOwnMac, 48'h02A5_3C96_0F71);
    write_reg(arpr_pkg::CfgOwnIp, 48'h0A00_0001);
    make_request(own_ip_q);
    frame_len = FrameBytes + 1;
    send_frame();
    make_request(own_ip_q);
    frame_len = FrameBytes - 1;
    send_frame();
    make_request(own_ip_q);
    frame_len = 1;
    send_frame();
    make_request(own_ip_q);
    frame_buf[OpAt + 1] = ArpReply[7:0];
    send_frame();
    settle();
  endtask

  task automatic test_output_fill();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    @(posedge clk_i);
    hold_left = FillHold;
    repeat (2) begin
      make_request(own_ip_q);
      send_frame();
    end
    make_request(own_ip_q);
    frame_len = 1;
    send_frame();
    settle();
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int n_bytes);
    int sent;
    sent = 0;
    write_reg(arpr_pkg::CfgOwnMac, 48'({$urandom, $urandom}));
    write_reg(arpr_pkg::CfgOwnIp, 48'($urandom));
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    while (sent < n_bytes) begin
      random_frame();
      send_frame();
      sent += frame_len;
    end
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_valid_i    = 1'b0;
    rx_i          = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    own_mac_q     = '0;
    own_ip_q      = '0;
    rx_fill       = 0;
    hold_left     = 0;
    errors        = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 9;
    snk_stall_pct = 55;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_frame_corners();
    test_random_traffic(55, 9, 24);
    test_output_fill();

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/arpr_pkg.sv
sv/arpr_ram.sv
sv/arpr_front.sv
sv/arpr_queue.sv
sv/arpr_back.sv
sv/arp_request_responder_core.sv
sv/arpr_checker.sv
test/tb_top.sv
